// ===== rtl/gxb_pkg.sv =====
package gxb_pkg;

    localparam int VALUE_W   = 64;
    localparam int SIZE_W    = 7;
    localparam int S_TDATA_W = 2 * VALUE_W;
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

endpackage

// ===== rtl/gxb_store.sv =====
module gxb_store #(
    parameter int VEC_BITS = 64,
    parameter int ADDR_W   = 6
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [VEC_BITS-1:0] rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [VEC_BITS-1:0] wr_data
);

    logic [VEC_BITS-1:0] mem [VEC_BITS];
    logic [VEC_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gf2_xor_basis_span_test.sv =====
// Keeps a fully reduced GF(2) basis of vectors of VEC_BITS bits, each pivoted on its lowest
// set bit, in a single memory with one read and one write port. An insert transaction
// (tuser = 0) reduces value_a and, if a nonzero remainder is left and the basis is not full,
// clears its pivot from the stored vectors and appends it; a query transaction (tuser = 1)
// reduces value_a XOR value_b and reports whether it lies in the span. Each transaction gives
// one result. The memory is walked one entry per cycle, once to reduce and, for an insert that
// appends, once more to clear the new pivot from the stored vectors. One transaction is
// processed at a time; the next one can be accepted in the same cycle as the result is
// issued, even while that result still waits on the master side.
module gf2_xor_basis_span_test #(
    parameter int VEC_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value_a [63:0], value_b [127:64]
    input  logic [gxb_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // in_span [0], added [1], basis_size [8:2], zero [15:9]
    output logic [gxb_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int VALUE_W = gxb_pkg::VALUE_W;
    localparam int SIZE_W  = gxb_pkg::SIZE_W;
    localparam int CNT_W   = $clog2(VEC_BITS + 1);
    localparam int ADDR_W  = (VEC_BITS > 1) ? $clog2(VEC_BITS) : 1;
    localparam logic [CNT_W-1:0] VEC_CNT = CNT_W'(VEC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ELIM,
        ST_APPEND,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic                func_reg;
    logic [VEC_BITS-1:0] vec_reg;
    logic [VEC_BITS-1:0] piv_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_ptr_reg;
    logic [ADDR_W-1:0]   rd_addr_q_reg;
    logic                pend_reg;
    logic                in_span_reg;
    logic                added_reg;
    logic                out_valid_reg;
    logic                out_span_reg;
    logic                out_added_reg;
    logic [SIZE_W-1:0]   out_size_reg;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VEC_BITS-1:0] rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VEC_BITS-1:0] wr_data;
    logic                walk_done;
    logic                hit;
    logic [VEC_BITS-1:0] vec_red;
    logic [VEC_BITS-1:0] in_vec;
    logic [SIZE_W-1:0]   size_ext;

    gxb_store #(
        .VEC_BITS (VEC_BITS),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        in_vec = s_tdata[VEC_BITS-1:0];
        if (s_tuser[0] == gxb_pkg::FUNC_QUERY) begin
            in_vec = in_vec ^ s_tdata[VALUE_W +: VEC_BITS];
        end
    end

    always_comb begin
        rd_en     = (state_reg == ST_REDUCE || state_reg == ST_ELIM) && (rd_ptr_reg != count_reg);
        rd_addr   = rd_ptr_reg[ADDR_W-1:0];
        walk_done = (rd_ptr_reg == count_reg) && !pend_reg;
        hit       = |(rd_data & (~rd_data + 1'b1) & vec_reg);
        vec_red   = hit ? (vec_reg ^ rd_data) : vec_reg;

        wr_en   = 1'b0;
        wr_addr = rd_addr_q_reg;
        wr_data = rd_data ^ vec_reg;
        case (state_reg)
            ST_ELIM: begin
                wr_en = pend_reg && (|(rd_data & piv_reg));
            end
            ST_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = vec_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        size_ext            = '0;
        size_ext[CNT_W-1:0] = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && state_reg != ST_RESULT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg   <= s_tuser[0];
                        vec_reg    <= in_vec;
                        rd_ptr_reg <= '0;
                        pend_reg   <= 1'b0;
                        state_reg  <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    pend_reg <= rd_en;
                    if (rd_en) begin
                        rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                        rd_addr_q_reg <= rd_addr;
                    end
                    if (pend_reg) begin
                        vec_reg <= vec_red;
                    end
                    if (walk_done) begin
                        in_span_reg <= (vec_reg == '0);
                        added_reg   <= 1'b0;
                        if (func_reg == gxb_pkg::FUNC_INSERT && vec_reg != '0
                            && count_reg != VEC_CNT) begin
                            piv_reg    <= vec_reg & (~vec_reg + 1'b1);
                            rd_ptr_reg <= '0;
                            state_reg  <= ST_ELIM;
                        end else begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_ELIM: begin
                    pend_reg <= rd_en;
                    if (rd_en) begin
                        rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                        rd_addr_q_reg <= rd_addr;
                    end
                    if (walk_done) begin
                        state_reg <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    count_reg <= count_reg + 1'b1;
                    added_reg <= 1'b1;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_span_reg  <= in_span_reg;
                        out_added_reg <= added_reg;
                        out_size_reg  <= size_ext;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gxb_pkg::M_TDATA_W - SIZE_W - 2){1'b0}},
                       out_size_reg, out_added_reg, out_span_reg};

`ifndef NO_ASSERTIONS
    a_no_same_entry : assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same basis entry");

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= VEC_CNT)
        else $error("basis count exceeds vector width");

    a_count_step : assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg))
            |-> (count_reg == $past(count_reg) + 1'b1 && $past(state_reg) == ST_APPEND))
        else $error("basis count changed outside an append");

    a_span_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_span_reg && out_added_reg))
        else $error("result marks both in_span and added");
`endif

endmodule
